>>> rtl/btpc_pkg.sv
package btpc_pkg;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned Latency  = 43;

  localparam logic [1:0] RegTemp  = 2'd0;
  localparam logic [1:0] RegPLow  = 2'd1;
  localparam logic [1:0] RegPHigh = 2'd2;
  localparam logic [1:0] RegPNine = 2'd3;

  localparam logic [31:0] Off64000  = 32'd64000;
  localparam logic [31:0] Base1M    = 32'd1048576;
  localparam logic [31:0] Scale3125 = 32'd3125;
  localparam logic [31:0] Sign32    = 32'h8000_0000;
  localparam logic [31:0] Bias32768 = 32'd32768;
  localparam logic [31:0] Round128  = 32'd128;

  // Fields that ride along with the divider.
  typedef struct packed {
    logic [31:0] tc;
    logic [31:0] fine;
    logic        dz;
    logic        dbl;
  } side_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return 32'(a * b);
  endfunction

endpackage

>>> rtl/baro_temp_press_compensation_core.sv
// Throughput: one sample pair per cycle; busy stays low, the pipeline never stalls.
// The pressure divide is a 32-stage restoring divider, one quotient bit per stage,
// which sets most of the latency.
// Reset (synchronous, rst_n low) clears all valid bits and the calibration registers.
// The receiver cannot stall: each result shows for one cycle with out_valid.
module baro_temp_press_compensation_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_raw_temp,
  input  logic [19:0]        in_raw_press,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               out_valid,
  output logic signed [31:0] out_temp_centi,
  output logic signed [31:0] out_fine_temp,
  output logic [31:0]        out_press_pa,
  output logic               out_div_zero
);

  // ---------------- calibration registers ----------------
  logic [47:0] temp_coeffs_r;
  logic [63:0] press_low_r, press_high_r;
  logic [15:0] press_nine_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_coeffs_r <= '0;
      press_low_r   <= '0;
      press_high_r  <= '0;
      press_nine_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btpc_pkg::RegTemp:  temp_coeffs_r <= cfg_data[47:0];
        btpc_pkg::RegPLow:  press_low_r   <= cfg_data;
        btpc_pkg::RegPHigh: press_high_r  <= cfg_data;
        btpc_pkg::RegPNine: press_nine_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Unpacked coefficients, widened to 32 bits: T1 and P1 zero-extended, the rest sign-extended.
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, temp_coeffs_r[15:0]};
  assign t2 = btpc_pkg::sx16(temp_coeffs_r[31:16]);
  assign t3 = btpc_pkg::sx16(temp_coeffs_r[47:32]);
  assign p1 = {16'd0, press_low_r[15:0]};
  assign p2 = btpc_pkg::sx16(press_low_r[31:16]);
  assign p3 = btpc_pkg::sx16(press_low_r[47:32]);
  assign p4 = btpc_pkg::sx16(press_low_r[63:48]);
  assign p5 = btpc_pkg::sx16(press_high_r[15:0]);
  assign p6 = btpc_pkg::sx16(press_high_r[31:16]);
  assign p7 = btpc_pkg::sx16(press_high_r[47:32]);
  assign p8 = btpc_pkg::sx16(press_high_r[63:48]);
  assign p9 = btpc_pkg::sx16(press_nine_r);

  // ---------------- front stages ----------------
  logic        v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;
  logic [19:0] adct1_r, adcp1_r;
  logic [31:0] adcp2_r, adcp3_r, adcp4_r, adcp5_r, adcp6_r, adcp7_r;
  logic [31:0] at2_r, dd2_r, fine3_r;
  logic [31:0] fine4_r, tc4_r, pa4_r, qq4_r;
  logic [31:0] fine5_r, tc5_r, m1_5_r, m2_5_r, m3_5_r, m4_5_r;
  logic [31:0] fine6_r, tc6_r, bsh6_r, a18_6_r;
  logic [31:0] fine7_r, tc7_r, bsh7_r, aa7_r;
  logic [31:0] fine8_r, tc8_r, den8_r, pnum8_r;

  logic [31:0] adct32, x1, d1, f4x5;
  logic [31:0] q4, b6;
  assign adct32 = {12'd0, adct1_r};
  assign x1     = (adct32 >> 3) - (t1 << 1);
  assign d1     = (adct32 >> 4) - t1;
  assign f4x5   = btpc_pkg::mul32(fine3_r, 32'd5);
  assign q4     = btpc_pkg::asr(btpc_pkg::asr(fine3_r, 1) - btpc_pkg::Off64000, 2);
  assign b6     = btpc_pkg::asr(btpc_pkg::asr(m1_5_r + m2_5_r, 2) + (p4 << 16), 12);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <= '0;
    end else begin
      {v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r} <=
        {start, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r};
    end
  end

  always_ff @(posedge clk) begin
    adct1_r <= in_raw_temp;
    adcp1_r <= in_raw_press;
    // stage 2: temperature products
    at2_r   <= btpc_pkg::asr(btpc_pkg::mul32(x1, t2), 11);
    dd2_r   <= btpc_pkg::mul32(d1, d1);
    adcp2_r <= {12'd0, adcp1_r};
    // stage 3: fine temperature
    fine3_r <= at2_r + btpc_pkg::asr(
                 btpc_pkg::mul32(btpc_pkg::asr(dd2_r, 12), t3), 14);
    adcp3_r <= adcp2_r;
    // stage 4: centi-degrees, pressure offset, square
    fine4_r <= fine3_r;
    tc4_r   <= btpc_pkg::asr(f4x5 + btpc_pkg::Round128, 8);
    pa4_r   <= btpc_pkg::asr(fine3_r, 1) - btpc_pkg::Off64000;
    qq4_r   <= btpc_pkg::mul32(q4, q4);
    adcp4_r <= adcp3_r;
    // stage 5: four coefficient products in parallel
    fine5_r <= fine4_r;
    tc5_r   <= tc4_r;
    m1_5_r  <= btpc_pkg::mul32(btpc_pkg::asr(qq4_r, 11), p6);
    m2_5_r  <= btpc_pkg::mul32(pa4_r, p5) << 1;
    m3_5_r  <= btpc_pkg::mul32(p3, btpc_pkg::asr(qq4_r, 13));
    m4_5_r  <= btpc_pkg::mul32(p2, pa4_r);
    adcp5_r <= adcp4_r;
    // stage 6: sums and shifts
    fine6_r <= fine5_r;
    tc6_r   <= tc5_r;
    bsh6_r  <= b6;
    a18_6_r <= btpc_pkg::asr(btpc_pkg::asr(m3_5_r, 3) + btpc_pkg::asr(m4_5_r, 1), 18);
    adcp6_r <= adcp5_r;
    // stage 7: scale by P1
    fine7_r <= fine6_r;
    tc7_r   <= tc6_r;
    bsh7_r  <= bsh6_r;
    aa7_r   <= btpc_pkg::mul32(btpc_pkg::Bias32768 + a18_6_r, p1);
    adcp7_r <= adcp6_r;
    // stage 8: divisor and scaled numerator
    fine8_r <= fine7_r;
    tc8_r   <= tc7_r;
    den8_r  <= btpc_pkg::asr(aa7_r, 15);
    pnum8_r <= btpc_pkg::mul32((btpc_pkg::Base1M - adcp7_r) - bsh7_r,
                               btpc_pkg::Scale3125);
  end

  // ---------------- restoring divider, one bit per stage ----------------
  logic                  dv_r   [0:btpc_pkg::DivSteps];
  logic [31:0]           dvd_r  [0:btpc_pkg::DivSteps]; // dividend in, quotient out
  logic [31:0]           rem_r  [0:btpc_pkg::DivSteps];
  logic [31:0]           den_r  [0:btpc_pkg::DivSteps];
  btpc_pkg::side_t       side_r [0:btpc_pkg::DivSteps];

  logic big8;
  assign big8 = (pnum8_r >= btpc_pkg::Sign32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= btpc_pkg::DivSteps; k++) dv_r[k] <= 1'b0;
    end else begin
      dv_r[0] <= v8_r;
      for (int k = 0; k < btpc_pkg::DivSteps; k++) dv_r[k+1] <= dv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    logic [32:0] trial;
    dvd_r[0]       <= big8 ? pnum8_r : (pnum8_r << 1);
    rem_r[0]       <= '0;
    den_r[0]       <= den8_r;
    side_r[0].tc   <= tc8_r;
    side_r[0].fine <= fine8_r;
    side_r[0].dz   <= (den8_r == 32'd0);
    side_r[0].dbl  <= big8;
    for (int k = 0; k < btpc_pkg::DivSteps; k++) begin
      trial = {rem_r[k], dvd_r[k][31]};
      if (trial >= {1'b0, den_r[k]}) begin
        rem_r[k+1] <= 32'(trial - {1'b0, den_r[k]});
        dvd_r[k+1] <= {dvd_r[k][30:0], 1'b1};
      end else begin
        rem_r[k+1] <= trial[31:0];
        dvd_r[k+1] <= {dvd_r[k][30:0], 1'b0};
      end
      den_r[k+1]  <= den_r[k];
      side_r[k+1] <= side_r[k];
    end
  end

  // ---------------- post stages ----------------
  logic            pv_r;
  logic [31:0]     pp_r, pq_r, pm_r;
  btpc_pkg::side_t ps_r;
  logic [31:0]     quot, qh, corr_a, corr_b;

  assign quot   = side_r[btpc_pkg::DivSteps].dbl ? (dvd_r[btpc_pkg::DivSteps] << 1)
                                                 : dvd_r[btpc_pkg::DivSteps];
  assign qh     = quot >> 3;
  assign corr_a = btpc_pkg::asr(btpc_pkg::mul32(p9, pq_r), 12);
  assign corr_b = btpc_pkg::asr(pm_r, 13);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv_r      <= dv_r[btpc_pkg::DivSteps];
      out_valid <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    pp_r <= quot;
    pq_r <= btpc_pkg::mul32(qh, qh) >> 13;
    pm_r <= btpc_pkg::mul32(quot >> 2, p8);
    ps_r <= side_r[btpc_pkg::DivSteps];
    out_temp_centi <= $signed(ps_r.tc);
    out_fine_temp  <= $signed(ps_r.fine);
    out_div_zero   <= ps_r.dz;
    out_press_pa   <= ps_r.dz ? 32'd0
                    : pp_r + btpc_pkg::asr(corr_a + corr_b + p7, 4);
  end

  // ---------------- checks ----------------
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_div_zero |-> out_press_pa == 32'd0)
    else $error("pressure not zero on divisor fault");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(btpc_pkg::Latency) out_valid)
    else $error("result strobe missing after start");

  a_div_flow: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[btpc_pkg::DivSteps] |=> pv_r)
    else $error("divider output lost");

endmodule

>>> dv/baro_temp_press_compensation_core_test.sv
module baro_temp_press_compensation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One compensated reading as the block reports it.
  typedef struct packed {
    logic [31:0] temp_centi;
    logic [31:0] fine_temp;
    logic [31:0] press_pa;
    logic        div_zero;
  } reading_t;

  // Calibration shadow plus the queue of predicted readings.
  class comp_scoreboard;
    logic [47:0] temp_cal;
    logic [63:0] press_cal_lo;
    logic [63:0] press_cal_hi;
    logic [15:0] press_cal_nine;
    reading_t    pending[$];
    int          mismatches;

    function void write_cal(logic [1:0] idx, logic [63:0] data);
      case (idx)
        btpc_pkg::RegTemp:  temp_cal = data[47:0];
        btpc_pkg::RegPLow:  press_cal_lo = data;
        btpc_pkg::RegPHigh: press_cal_hi = data;
        btpc_pkg::RegPNine: press_cal_nine = data[15:0];
        default: ;
      endcase
    endfunction

    static function logic [31:0] sra(logic [31:0] x, int n);
      return $unsigned($signed(x) >>> n);
    endfunction

    static function logic [31:0] sext(logic [15:0] v);
      return {{16{v[15]}}, v};
    endfunction

    function reading_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
      reading_t r;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [31:0] adc_t, adc_p, var1, var2, dlt, fine, sq, prs;
      adc_t = {12'd0, raw_t};
      adc_p = {12'd0, raw_p};
      t1 = {16'd0, temp_cal[15:0]};
      t2 = sext(temp_cal[31:16]);
      t3 = sext(temp_cal[47:32]);
      p1 = {16'd0, press_cal_lo[15:0]};
      p2 = sext(press_cal_lo[31:16]);
      p3 = sext(press_cal_lo[47:32]);
      p4 = sext(press_cal_lo[63:48]);
      p5 = sext(press_cal_hi[15:0]);
      p6 = sext(press_cal_hi[31:16]);
      p7 = sext(press_cal_hi[47:32]);
      p8 = sext(press_cal_hi[63:48]);
      p9 = sext(press_cal_nine);
      // temperature path
      var1 = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      dlt = (adc_t >> 4) - t1;
      var2 = sra(sra(dlt * dlt, 12) * t3, 14);
      fine = var1 + var2;
      r.fine_temp = fine;
      r.temp_centi = sra(fine * 32'd5 + btpc_pkg::Round128, 8);
      // pressure path
      var1 = sra(fine, 1) - btpc_pkg::Off64000;
      sq = sra(var1, 2);
      var2 = sra(sq * sq, 11) * p6;
      var2 = var2 + ((var1 * p5) << 1);
      var2 = sra(var2, 2) + (p4 << 16);
      var1 = sra(sra(p3 * sra(sq * sq, 13), 3) + sra(p2 * var1, 1), 18);
      var1 = sra((btpc_pkg::Bias32768 + var1) * p1, 15);
      r.div_zero = (var1 == 32'd0);
      if (r.div_zero) begin
        prs = 32'd0;
      end else begin
        prs = ((btpc_pkg::Base1M - adc_p) - sra(var2, 12)) * btpc_pkg::Scale3125;
        // big scaled values divide first so the doubling cannot overflow
        if (prs < btpc_pkg::Sign32) prs = (prs << 1) / var1;
        else prs = (prs / var1) * 32'd2;
        sq = ((prs >> 3) * (prs >> 3)) >> 13;
        var1 = sra(p9 * sq, 12);
        var2 = sra((prs >> 2) * p8, 13);
        prs = prs + sra(var1 + var2 + p7, 4);
      end
      r.press_pa = prs;
      return r;
    endfunction

    function void note_sample(logic [19:0] raw_t, logic [19:0] raw_p);
      pending.push_back(compensate(raw_t, raw_p));
    endfunction

    function void check_reading(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: fine=%h", got.fine_temp);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: tc %h/%h fine %h/%h p %h/%h dz %b/%b (exp/act)",
                   want.temp_centi, got.temp_centi, want.fine_temp, got.fine_temp,
                   want.press_pa, got.press_pa, want.div_zero, got.div_zero);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [19:0] in_raw_temp;
  logic [19:0] in_raw_press;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        out_valid;
  logic signed [31:0] out_temp_centi;
  logic signed [31:0] out_fine_temp;
  logic [31:0] out_press_pa;
  logic        out_div_zero;

  comp_scoreboard sb;
  int send_idle_pct;

  baro_temp_press_compensation_core DUT (
    .clk, .rst_n, .start, .busy, .in_raw_temp, .in_raw_press,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .out_valid, .out_temp_centi, .out_fine_temp, .out_press_pa, .out_div_zero
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Result monitor: a strobe is a transfer, the receiver never stalls.
  always @(posedge clk) begin
    reading_t got;
    if (rst_n && out_valid) begin
      got.temp_centi = out_temp_centi;
      got.fine_temp = out_fine_temp;
      got.press_pa = out_press_pa;
      got.div_zero = out_div_zero;
      sb.check_reading(got);
    end
  end

  // Register write, only issued with the pipeline empty.
  task automatic write_cal(logic [1:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_cal(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One sample transfer; start stays high across back-to-back items.
  task automatic send_sample(logic [19:0] raw_t, logic [19:0] raw_p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_raw_temp <= raw_t;
    in_raw_press <= raw_p;
    do @(posedge clk); while (busy);
    sb.note_sample(raw_t, raw_p);
  endtask

  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (btpc_pkg::Latency + 5) @(posedge clk);
  endtask

  function automatic logic [15:0] coef16;
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [19:0] raw20;
    case ($urandom_range(7))
      0: return 20'h00000;
      1: return 20'hfffff;
      default: return 20'($urandom);
    endcase
  endfunction

  // Calibration close to a real part so pressure lands in range
  task automatic load_typical;
    write_cal(btpc_pkg::RegTemp, {16'h0000, 16'hfc18, 16'h6738, 16'h6e9f});
    write_cal(btpc_pkg::RegPLow, {16'h1a8c, 16'hd0d0, 16'hd614, 16'h8e9a});
    write_cal(btpc_pkg::RegPHigh, {16'hffec, 16'hf82f, 16'h8c3c, 16'hfff9});
    write_cal(btpc_pkg::RegPNine, 64'h0000_0000_0000_1770);
  endtask

  task automatic load_random;
    write_cal(btpc_pkg::RegTemp, {$urandom, $urandom});
    write_cal(btpc_pkg::RegPLow, {coef16(), coef16(), coef16(), coef16()});
    write_cal(btpc_pkg::RegPHigh, {coef16(), coef16(), coef16(), coef16()});
    write_cal(btpc_pkg::RegPNine, {$urandom, $urandom});
  endtask

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new();
    sb.write_cal(btpc_pkg::RegTemp, 64'd0);
    sb.write_cal(btpc_pkg::RegPLow, 64'd0);
    sb.write_cal(btpc_pkg::RegPHigh, 64'd0);
    sb.write_cal(btpc_pkg::RegPNine, 64'd0);
    send_idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_raw_temp = '0;
    in_raw_press = '0;
    cfg_valid = 1'b0;
    cfg_index = btpc_pkg::RegTemp;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: P1 is zero, so the divisor is zero for every sample.
    send_sample(20'h00000, 20'hfffff);
    send_sample(20'hfffff, 20'h00000);
    drain();

    // Typical calibration, extremes of both raw fields.
    load_typical();
    send_sample(20'h7e9b0, 20'h655a3);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hfffff, 20'hfffff);
    send_sample(20'h00000, 20'hfffff);
    send_sample(20'hfffff, 20'h00000);
    send_sample(20'h80000, 20'h80000);
    // Low raw pressure gives a scaled value past the sign bit.
    send_sample(20'h7e9b0, 20'h00001);
    drain();

    // Calibration extremes: all ones and all sign bits.
    write_cal(btpc_pkg::RegTemp, 64'hffff_ffff_ffff_ffff);
    write_cal(btpc_pkg::RegPLow, 64'hffff_ffff_ffff_ffff);
    write_cal(btpc_pkg::RegPHigh, 64'hffff_ffff_ffff_ffff);
    write_cal(btpc_pkg::RegPNine, 64'hffff_ffff_ffff_ffff);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hfffff, 20'hfffff);
    send_sample(20'h55555, 20'haaaaa);
    drain();
    write_cal(btpc_pkg::RegTemp, {16'h0, 16'h7fff, 16'h8000, 16'hffff});
    write_cal(btpc_pkg::RegPLow, {16'h7fff, 16'h8000, 16'h7fff, 16'hffff});
    write_cal(btpc_pkg::RegPHigh, {16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    write_cal(btpc_pkg::RegPNine, 64'h8000);
    send_sample(20'haaaaa, 20'h55555);
    send_sample(20'hfffff, 20'h00000);
    drain();

    // Random phases: sender idles, then none; typical cal in every third phase, random cal otherwise.
    for (int ph = 0; ph < 12; ph++) begin
      send_idle_pct = (ph < 4) ? 32 : (ph < 8) ? 84 : 0;
      if (ph % 3 == 0) load_typical();
      else load_random();
      for (int k = 0; k < 70; k++) begin
        if (ph % 3 == 0)
          send_sample(20'h70000 + 20'($urandom_range(20'h1ffff)), raw20());
        else
          send_sample(raw20(), raw20());
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
